// File: rtl/core/iqtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_pkg
// Shared types and constants for the quarter-turn image rotator.
// ----------------------------------------------------------------------------
package iqtr_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int MAX_BPP        = 4;

    localparam int PIX_W = 32;
    localparam int CFG_W = 7;
    localparam int IDX_W = 2;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_HEIGHT = 2'd1;
    localparam t_cfg_idx REG_BPP    = 2'd2;
    localparam t_cfg_idx REG_CW     = 2'd3;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 7'd64;
    localparam logic [2:0]       RST_BPP    = 3'd4;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel_in;
    } t_rot_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             end_of_frame;
    } t_rot_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic clear;
    } t_dp_cmd;

endpackage

// File: rtl/core/iqtr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iqtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/iqtr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_ctrl
// Controller: accepts words, issues load/fetch/clear commands, times strobe.
// ----------------------------------------------------------------------------
module iqtr_ctrl
    import iqtr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_func,
    input  logic    i_cfg_we,
    output logic    busy,
    output logic    o_strobe,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy   = (r_state == ST_INIT);
    assign accept = start && !busy;

    always_comb begin
        o_cmd.load  = accept && !i_func;
        o_cmd.fetch = accept && i_func;
        o_cmd.clear = i_cfg_we;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE, ST_EMIT: begin
                n_state = o_cmd.fetch ? ST_EMIT : ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_strobe = (r_state == ST_EMIT);

    // result word in the cycle after a fetch
    a_strobe_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fetch |=> o_strobe)
        else $error("fetch not followed by strobe");

    a_no_strobe_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load || !accept) |=> !o_strobe)
        else $error("strobe without fetch");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held past start-up");

endmodule

// File: rtl/core/iqtr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqtr_datapath
// Config registers, position counters, address generation and frame store.
// ----------------------------------------------------------------------------
module iqtr_datapath
    import iqtr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0] i_pixel,
    output t_rot_out         o_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CWX   = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int CWY   = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;
    localparam int BLIM  = (MAX_BPP < 4) ? MAX_BPP : 4;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [2:0]       r_bpp;
    logic             r_cw;

    logic [XW-1:0] r_load_col;
    logic [YW-1:0] r_load_row;
    logic [YW-1:0] r_emit_col;
    logic [XW-1:0] r_emit_row;
    logic          r_last;

    logic [CWX-1:0]   width_ext;
    logic [CWY-1:0]   height_ext;
    logic [XW-1:0]    w_m1;
    logic [YW-1:0]    h_m1;
    logic [XW-1:0]    src_x;
    logic [YW-1:0]    src_y;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [PIX_W-1:0] rdata;
    logic [PIX_W-1:0] mask;
    logic [2:0]       bpp_eff;
    logic             at_last;

    // clamped dimensions, minus one
    always_comb begin
        width_ext  = CWX'(r_width);
        height_ext = CWY'(r_height);
        if (width_ext == '0) begin
            w_m1 = '0;
        end else if (width_ext > CWX'(MAX_WIDTH)) begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = XW'(width_ext - CWX'(1));
        end
        if (height_ext == '0) begin
            h_m1 = '0;
        end else if (height_ext > CWY'(MAX_HEIGHT)) begin
            h_m1 = YW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = YW'(height_ext - CWY'(1));
        end
    end

    always_comb begin
        if (r_cw) begin
            src_x = r_emit_row;
            src_y = h_m1 - r_emit_col;
        end else begin
            src_x = w_m1 - r_emit_row;
            src_y = r_emit_col;
        end
        waddr   = AW'(r_load_row) * AW'(MAX_WIDTH) + AW'(r_load_col);
        raddr   = AW'(src_y) * AW'(MAX_WIDTH) + AW'(src_x);
        at_last = (r_emit_col == h_m1) && (r_emit_row == w_m1);
    end

    // byte mask from the bytes-per-pixel setting
    always_comb begin
        if (r_bpp == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (r_bpp > 3'(BLIM)) begin
            bpp_eff = 3'(BLIM);
        end else begin
            bpp_eff = r_bpp;
        end
        for (int k = 0; k < PIX_W / 8; k++) begin
            mask[k*8 +: 8] = (3'(k) < bpp_eff) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_bpp    <= RST_BPP;
            r_cw     <= 1'b1;
        end else if (i_cmd.clear) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_BPP:    r_bpp    <= i_cfg_data[2:0];
                REG_CW:     r_cw     <= i_cfg_data[0];
                default:    r_cw     <= r_cw;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_load_col <= '0;
            r_load_row <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_load_col == w_m1) begin
                    r_load_col <= '0;
                    r_load_row <= (r_load_row == h_m1) ? '0 : r_load_row + YW'(1);
                end else begin
                    r_load_col <= r_load_col + XW'(1);
                end
            end
            if (i_cmd.fetch) begin
                if (r_emit_col == h_m1) begin
                    r_emit_col <= '0;
                    r_emit_row <= (r_emit_row == w_m1) ? '0 : r_emit_row + XW'(1);
                end else begin
                    r_emit_col <= r_emit_col + YW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_last <= at_last;
        end
    end

    iqtr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (waddr),
        .i_wdata (i_pixel),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_data.pixel_out    = rdata & mask;
    assign o_data.end_of_frame = r_last;

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_col <= w_m1) && (r_load_row <= h_m1))
        else $error("load position outside frame");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit_col <= h_m1) && (r_emit_row <= w_m1))
        else $error("fetch position outside frame");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fetch && at_last && !i_cmd.clear) |=> (r_emit_col == '0 && r_emit_row == '0))
        else $error("fetch position did not wrap after frame end");

endmodule

// File: rtl/core/image_quarter_turn_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_quarter_turn_rotator
// Rotates an image a quarter turn through an on-chip frame store.
//
// Usage: a word is taken on start while busy is low. func low loads the next
// source pixel in raster order; func high fetches the next pixel of the
// turned image in destination raster order. Each fetch gives one result word
// on o_data, with o_strobe high for exactly one cycle, in the cycle after the
// fetch is taken (registered frame store read). Loads give no result.
// Throughput is one word per clock while busy is low, loads and fetches
// freely mixed. end_of_frame marks the last pixel of the turned frame. The
// receiver cannot stall the block. Configuration is written through
// i_cfg_we/i_cfg_index/i_cfg_data with no word in flight; any write returns
// all positions to the frame start. After reset busy is high for one cycle,
// the registers hold 64 x 64, four bytes per pixel, clockwise, and the frame
// store contents are undefined until loaded. Fetches should follow a full
// frame load.
// ----------------------------------------------------------------------------
module image_quarter_turn_rotator
    import iqtr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_rot_in          i_data,
    output logic             o_strobe,
    output t_rot_out         o_data,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;

    iqtr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_data.func),
        .i_cfg_we (i_cfg_we),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    iqtr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_data.pixel_in),
        .o_data      (o_data)
    );

endmodule

// File: tb/tb_image_quarter_turn_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_quarter_turn_rotator
// Self-checking bench for the quarter-turn rotator. Frames of source pixels
// are loaded and read back turned, under a sequence of width, height, pixel
// size and direction settings, extremes included. A mirror of the frame store
// and of the position counters predicts every fetched pixel and its
// end-of-frame flag, and each strobed result is checked against the oldest
// prediction. Input words arrive with random gaps and bursts.
// ----------------------------------------------------------------------------
module tb_image_quarter_turn_rotator
    import iqtr_pkg::*;
;

    localparam int  TB_MAXW    = DEF_MAX_WIDTH;
    localparam int  TB_MAXH    = DEF_MAX_HEIGHT;
    localparam int  SETTLE     = 4;
    localparam int  SILENT_MAX = 2000;
    localparam int  MIX_TARGET = 500;
    localparam int  AREA_CAP   = 128;
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_rot_in          i_data      = '0;
    logic             o_strobe;
    t_rot_out         o_data;
    logic             i_cfg_we    = 1'b0;
    t_cfg_idx         i_cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    image_quarter_turn_rotator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_data      (i_data),
        .o_strobe    (o_strobe),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block
    logic [PIX_W-1:0] mirror_store [TB_MAXW*TB_MAXH];
    int               ld_col, ld_row, em_col, em_row;
    logic [CFG_W-1:0] reg_w, reg_h;
    logic [2:0]       reg_bpp;
    logic             reg_cw;

    t_rot_in  words_waiting [$];
    t_rot_out pixels_due [$];
    t_rot_out next_due;
    int       words_queued = 0;
    int       words_taken  = 0;
    int       n_errors     = 0;
    bit       word_taken   = 1'b0;
    int       gap_left     = 0;
    int       burst_left   = 0;
    int       silent       = 0;

    // stimulus side view of the geometry
    logic [CFG_W-1:0] gen_w = RST_WIDTH;
    logic [CFG_W-1:0] gen_h = RST_HEIGHT;
    int               cov_w = 0;
    int               cov_h = 0;

    function automatic int eff_dim(logic [CFG_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    function automatic logic [PIX_W-1:0] byte_mask(logic [2:0] b);
        int n;
        n = (b == 0) ? 1 : ((b > MAX_BPP) ? MAX_BPP : b);
        if (n >= 4) return '1;
        return (32'h1 << (8 * n)) - 1;
    endfunction

    task automatic report_mismatch(string msg);
        if (n_errors < 100) $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic apply_reg_write(t_cfg_idx idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_WIDTH:  reg_w = val;
            REG_HEIGHT: reg_h = val;
            REG_BPP:    reg_bpp = val[2:0];
            REG_CW:     reg_cw = val[0];
            default: ;
        endcase
        ld_col = 0; ld_row = 0;
        em_col = 0; em_row = 0;
    endtask

    task automatic advance_rotator(t_rot_in word);
        int w, h, sx, sy;
        t_rot_out res;
        w = eff_dim(reg_w, TB_MAXW);
        h = eff_dim(reg_h, TB_MAXH);
        if (word.func == FUNC_LOAD) begin
            if (ld_col >= w || ld_row >= h) begin
                ld_col = 0; ld_row = 0;
            end
            mirror_store[ld_row * TB_MAXW + ld_col] = word.pixel_in;
            ld_col++;
            if (ld_col >= w) begin
                ld_col = 0;
                ld_row++;
                if (ld_row >= h) ld_row = 0;
            end
        end else begin
            // em_col walks destination x over 0..h-1, em_row destination y
            if (em_col >= h || em_row >= w) begin
                em_col = 0; em_row = 0;
            end
            if (reg_cw) begin
                sx = em_row;
                sy = h - 1 - em_col;
            end else begin
                sx = w - 1 - em_row;
                sy = em_col;
            end
            res.pixel_out    = mirror_store[sy * TB_MAXW + sx] & byte_mask(reg_bpp);
            res.end_of_frame = (em_col == h - 1) && (em_row == w - 1);
            pixels_due.push_back(res);
            em_col++;
            if (em_col >= h) begin
                em_col = 0;
                em_row++;
                if (em_row >= w) em_row = 0;
            end
        end
    endtask

    function automatic int draw_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(30, 200);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !word_taken)) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (words_waiting.size() > 0) begin
                i_data   <= words_waiting.pop_front();
                start    <= 1'b1;
                gap_left = draw_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_w = RST_WIDTH; reg_h = RST_HEIGHT;
            reg_bpp = RST_BPP; reg_cw = 1'b1;
            ld_col = 0; ld_row = 0; em_col = 0; em_row = 0;
            word_taken = 1'b0;
        end else begin
            if (o_strobe) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("result word with nothing due");
                end else begin
                    next_due = pixels_due.pop_front();
                    if (o_data.pixel_out !== next_due.pixel_out)
                        report_mismatch($sformatf("pixel_out got %h want %h",
                            o_data.pixel_out, next_due.pixel_out));
                    if (o_data.end_of_frame !== next_due.end_of_frame)
                        report_mismatch($sformatf("end_of_frame got %b want %b",
                            o_data.end_of_frame, next_due.end_of_frame));
                end
            end
            if (i_cfg_we) apply_reg_write(i_cfg_index, i_cfg_data);
            word_taken = start && !busy;
            if (word_taken) begin
                words_taken++;
                advance_rotator(i_data);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || i_cfg_we) silent = 0;
            else silent++;
            if (silent >= SILENT_MAX) begin
                $display("timeout: no word moved for %0d cycles", SILENT_MAX);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic queue_word(logic f, logic [PIX_W-1:0] pix);
        t_rot_in word;
        word.func     = f;
        word.pixel_in = pix;
        words_waiting.push_back(word);
        words_queued++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (words_taken != words_queued || pixels_due.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_WIDTH) gen_w = val;
        else if (idx == REG_HEIGHT) gen_h = val;
    endtask

    task automatic load_frame();
        int ew, eh;
        ew = eff_dim(gen_w, TB_MAXW);
        eh = eff_dim(gen_h, TB_MAXH);
        repeat (ew * eh) queue_word(FUNC_LOAD, $urandom());
        if (ew >= cov_w && eh >= cov_h) begin
            cov_w = ew;
            cov_h = eh;
        end
    endtask

    task automatic mix_words(int n, int fetch_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < fetch_pct) queue_word(FUNC_FETCH, $urandom());
            else queue_word(FUNC_LOAD, $urandom());
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return CFG_W'(64);
        if (r == 2) return CFG_W'($urandom_range(65, 127));
        if (r == 3) return CFG_W'($urandom_range(9, 63));
        return CFG_W'($urandom_range(1, 8));
    endfunction

    initial begin
        int area, n;
        bit wr_w, wr_h, wr_b, wr_c;
        logic [CFG_W-1:0] nw, nh;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small frame, extreme pixel values, clockwise then anticlockwise
        write_reg(REG_WIDTH, 7'd3);
        write_reg(REG_HEIGHT, 7'd2);
        queue_word(FUNC_LOAD, 32'h0000_0000);
        queue_word(FUNC_LOAD, 32'hFFFF_FFFF);
        queue_word(FUNC_LOAD, 32'h8000_0000);
        queue_word(FUNC_LOAD, 32'h0000_0001);
        queue_word(FUNC_LOAD, 32'hAAAA_AAAA);
        queue_word(FUNC_LOAD, 32'h5555_5555);
        cov_w = 3;
        cov_h = 2;
        repeat (7) queue_word(FUNC_FETCH, 32'hFFFF_FFFF);
        write_reg(REG_CW, 7'h7E);
        repeat (6) queue_word(FUNC_FETCH, 32'h0000_0000);
        // zero pixel size taken as one byte, mask applied at fetch
        write_reg(REG_BPP, 7'h78);
        repeat (3) queue_word(FUNC_FETCH, 32'h1234_5678);
        // zero dimensions taken as one
        write_reg(REG_WIDTH, 7'd0);
        write_reg(REG_HEIGHT, 7'd0);
        queue_word(FUNC_LOAD, 32'hFFFF_FFFF);
        repeat (2) queue_word(FUNC_FETCH, 32'h0000_0000);

        // widest frame, oversized width and pixel size saturate
        write_reg(REG_WIDTH, 7'd127);
        write_reg(REG_HEIGHT, 7'd1);
        write_reg(REG_BPP, 7'd7);
        write_reg(REG_CW, 7'd1);
        load_frame();
        mix_words(TB_MAXW + 1, 100);
        write_reg(REG_CW, 7'd0);
        mix_words(TB_MAXW + 1, 100);

        // random settings
        while (words_queued < MIX_TARGET) begin
            wr_w = ($urandom_range(0, 99) < 60);
            wr_h = ($urandom_range(0, 99) < 60);
            wr_b = ($urandom_range(0, 99) < 60);
            wr_c = ($urandom_range(0, 99) < 60);
            nw = wr_w ? pick_dim() : gen_w;
            nh = wr_h ? pick_dim() : gen_h;
            if (eff_dim(nw, TB_MAXW) * eff_dim(nh, TB_MAXH) > AREA_CAP) begin
                nh = CFG_W'($urandom_range(1, 2));
                wr_h = 1'b1;
            end
            if (wr_w) write_reg(REG_WIDTH, nw);
            if (wr_h) write_reg(REG_HEIGHT, nh);
            if (wr_b) write_reg(REG_BPP, CFG_W'($urandom_range(0, 127)));
            if (wr_c) write_reg(REG_CW, CFG_W'($urandom_range(0, 127)));
            if (eff_dim(gen_w, TB_MAXW) > cov_w || eff_dim(gen_h, TB_MAXH) > cov_h
                    || $urandom_range(0, 99) < 40)
                load_frame();
            area = eff_dim(gen_w, TB_MAXW) * eff_dim(gen_h, TB_MAXH);
            n = $urandom_range(1, (2 * area + 4 < 64) ? 2 * area + 4 : 64);
            mix_words(n, $urandom_range(30, 90));
        end

        wait_idle();
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/iqtr_pkg.sv
rtl/core/iqtr_ram.sv
rtl/core/iqtr_ctrl.sv
rtl/core/iqtr_datapath.sv
rtl/core/image_quarter_turn_rotator.sv
tb/tb_image_quarter_turn_rotator.sv
